>>> hw/rtl/commit_header_field_tagger_assert.svh
// Assertion macros shared by the checker modules of the commit header field tagger.
`ifndef COMMIT_HEADER_FIELD_TAGGER_ASSERT_SVH
`define COMMIT_HEADER_FIELD_TAGGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/chftag_pkg.sv
package chftag_pkg;

    // Characters that drive the header grammar.
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    // Field tags.
    localparam logic [3:0] TAG_SEP            = 4'd0;
    localparam logic [3:0] TAG_TREE           = 4'd1;
    localparam logic [3:0] TAG_PARENT         = 4'd2;
    localparam logic [3:0] TAG_AUTHOR_NAME    = 4'd3;
    localparam logic [3:0] TAG_COMMITTER_NAME = 4'd7;
    localparam logic [3:0] TAG_MESSAGE        = 4'd11;

    // Parse status reported with the last byte of an object.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MALFORMED  = 2'd1;
    localparam logic [1:0] ST_NO_MESSAGE = 2'd2;

    // Keyword candidates.
    localparam logic [2:0] KW_NONE      = 3'd0;
    localparam logic [2:0] KW_TREE      = 3'd1;
    localparam logic [2:0] KW_PARENT    = 3'd2;
    localparam logic [2:0] KW_AUTHOR    = 3'd3;
    localparam logic [2:0] KW_COMMITTER = 3'd4;

    // Result queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // One tagged result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] field_tag;
        logic       end_of_object;
        logic [1:0] parse_status;
    } t_result;

    // Up to two results produced by one parsed byte: the held byte, then the final byte.
    typedef struct packed {
        logic    held_en;
        t_result held;
        logic    last_en;
        t_result last;
    } t_push;

    // Length of each keyword in characters.
    function automatic logic [3:0] kw_len(input logic [2:0] cand);
        logic [3:0] len;
        unique case (cand)
            KW_TREE:      len = 4'd4;
            KW_PARENT:    len = 4'd6;
            KW_AUTHOR:    len = 4'd6;
            KW_COMMITTER: len = 4'd9;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    // Character at a given position of a keyword; beyond its end it reads as zero.
    function automatic logic [7:0] kw_char(input logic [2:0] cand, input logic [3:0] pos);
        logic [71:0] txt;
        logic [71:0] sh;
        unique case (cand)
            KW_TREE:      txt = {"tree", 40'h0};
            KW_PARENT:    txt = {"parent", 24'h0};
            KW_AUTHOR:    txt = {"author", 24'h0};
            KW_COMMITTER: txt = "committer";
            default:      txt = '0;
        endcase
        sh = txt << {pos, 3'b000};
        return sh[71:64];
    endfunction

endpackage

>>> hw/rtl/chftag_parse.sv
module chftag_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_final,
    output chftag_pkg::t_push   o_push
);
    import chftag_pkg::*;

    typedef enum logic [10:0] {
        PH_LINE_START   = 11'b000_0000_0001,
        PH_KEYWORD      = 11'b000_0000_0010,
        PH_TREE         = 11'b000_0000_0100,
        PH_PARENT       = 11'b000_0000_1000,
        PH_NAME         = 11'b000_0001_0000,
        PH_EMAIL        = 11'b000_0010_0000,
        PH_SKIP_EMAIL   = 11'b000_0100_0000,
        PH_DATE         = 11'b000_1000_0000,
        PH_ZONE         = 11'b001_0000_0000,
        PH_SKIP_UNKNOWN = 11'b010_0000_0000,
        PH_MESSAGE      = 11'b100_0000_0000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_kpos, n_kpos;
    logic [2:0] r_kcand, n_kcand;
    logic       r_mal, n_mal;
    logic       r_msg, n_msg;
    logic [7:0] r_held_byte;
    logic [3:0] r_held_tag;
    logic       r_held_valid;

    logic [3:0] tag;
    logic [3:0] person_base;
    logic       retag;
    logic       kw_known;
    logic       open_line;
    logic [1:0] status;

    assign person_base = (r_kcand == KW_COMMITTER) ? TAG_COMMITTER_NAME : TAG_AUTHOR_NAME;
    assign kw_known    = (r_kcand != KW_NONE);

    // Next parse state and the tag of the incoming byte.
    always_comb begin
        n_phase = r_phase;
        n_kpos  = r_kpos;
        n_kcand = r_kcand;
        n_mal   = r_mal;
        n_msg   = r_msg;
        tag     = TAG_SEP;
        retag   = 1'b0;
        unique case (r_phase)
            PH_LINE_START: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_MESSAGE;
                end else if (i_byte == CH_SP) begin
                    n_phase = PH_SKIP_UNKNOWN;
                end else begin
                    n_kcand = (i_byte == "t") ? KW_TREE :
                              (i_byte == "p") ? KW_PARENT :
                              (i_byte == "a") ? KW_AUTHOR :
                              (i_byte == "c") ? KW_COMMITTER : KW_NONE;
                    n_kpos  = 4'd1;
                    n_phase = PH_KEYWORD;
                end
            end
            PH_KEYWORD: begin
                if (i_byte == CH_NL) begin
                    n_mal   = 1'b1;
                    n_phase = PH_LINE_START;
                end else if (i_byte == CH_SP) begin
                    if (kw_known && r_kpos == kw_len(r_kcand)) begin
                        n_phase = (r_kcand == KW_TREE)   ? PH_TREE :
                                  (r_kcand == KW_PARENT) ? PH_PARENT : PH_NAME;
                    end else begin
                        n_phase = PH_SKIP_UNKNOWN;
                    end
                end else if (kw_known && r_kpos < kw_len(r_kcand) &&
                             i_byte == kw_char(r_kcand, r_kpos)) begin
                    n_kpos = r_kpos + 4'd1;
                end else begin
                    n_kcand = KW_NONE;
                end
            end
            PH_TREE, PH_PARENT: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_LINE_START;
                end else begin
                    tag = (r_phase == PH_TREE) ? TAG_TREE : TAG_PARENT;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_LT) begin
                    // The byte before '<' is waiting in the hold stage: make it a separator.
                    retag   = r_held_valid;
                    n_phase = PH_EMAIL;
                end else if (i_byte == CH_NL) begin
                    n_mal   = 1'b1;
                    n_phase = PH_LINE_START;
                end else begin
                    tag = person_base;
                end
            end
            PH_EMAIL: begin
                if (i_byte == CH_GT) begin
                    n_phase = PH_SKIP_EMAIL;
                end else if (i_byte == CH_NL) begin
                    n_mal   = 1'b1;
                    n_phase = PH_LINE_START;
                end else begin
                    tag = person_base + 4'd1;
                end
            end
            PH_SKIP_EMAIL: begin
                n_phase = PH_DATE;
            end
            PH_DATE: begin
                if (i_byte == CH_SP) begin
                    n_phase = PH_ZONE;
                end else if (i_byte == CH_NL) begin
                    n_mal   = 1'b1;
                    n_phase = PH_LINE_START;
                end else begin
                    tag = person_base + 4'd2;
                end
            end
            PH_ZONE: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_LINE_START;
                end else begin
                    tag = person_base + 4'd3;
                end
            end
            PH_SKIP_UNKNOWN: begin
                n_phase = PH_MESSAGE;
            end
            default: begin
                n_phase = PH_MESSAGE;
                n_msg   = 1'b1;
                tag     = TAG_MESSAGE;
            end
        endcase
    end

    // Status of an object that ends with this byte; malformed wins over no message.
    assign open_line = !(n_phase == PH_LINE_START || n_phase == PH_MESSAGE ||
                         n_phase == PH_SKIP_UNKNOWN);
    assign status    = (n_mal || open_line) ? ST_MALFORMED :
                       (n_msg ? ST_OK : ST_NO_MESSAGE);

    // Results of this byte: the held byte first, then the final byte itself.
    always_comb begin
        o_push.held_en              = i_step && r_held_valid;
        o_push.held.out_byte        = r_held_byte;
        o_push.held.field_tag       = retag ? TAG_SEP : r_held_tag;
        o_push.held.end_of_object   = 1'b0;
        o_push.held.parse_status    = ST_OK;
        o_push.last_en              = i_step && i_final;
        o_push.last.out_byte        = i_byte;
        o_push.last.field_tag       = tag;
        o_push.last.end_of_object   = 1'b1;
        o_push.last.parse_status    = status;
    end

    // Parser state; the final byte returns everything to the line start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LINE_START;
            r_kpos       <= '0;
            r_kcand      <= KW_NONE;
            r_mal        <= 1'b0;
            r_msg        <= 1'b0;
            r_held_valid <= 1'b0;
        end else if (i_step) begin
            if (i_final) begin
                r_phase      <= PH_LINE_START;
                r_kpos       <= '0;
                r_kcand      <= KW_NONE;
                r_mal        <= 1'b0;
                r_msg        <= 1'b0;
                r_held_valid <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_kpos       <= n_kpos;
                r_kcand      <= n_kcand;
                r_mal        <= n_mal;
                r_msg        <= n_msg;
                r_held_valid <= 1'b1;
            end
        end
    end

    // Hold stage payload.
    always_ff @(posedge i_clk) begin
        if (i_step && !i_final) begin
            r_held_byte <= i_byte;
            r_held_tag  <= tag;
        end
    end

endmodule

>>> hw/rtl/chftag_outq.sv
module chftag_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  chftag_pkg::t_push     i_push,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output chftag_pkg::t_result   o_result
);
    import chftag_pkg::*;

    t_result           r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr, r_rd;
    logic [OQ_CW-1:0]  r_cnt;
    logic [OQ_AW-1:0]  last_addr;
    logic [1:0]        push_cnt;
    logic              pop;

    assign push_cnt  = {1'b0, i_push.held_en} + {1'b0, i_push.last_en};
    assign pop       = o_valid && i_ready;
    assign last_addr = i_push.held_en ? r_wr + OQ_AW'(1) : r_wr;

    // Room for a full pair of results, whatever the consumer does this cycle.
    assign o_space  = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];

    // Queue storage: held byte first, final byte after it.
    always_ff @(posedge i_clk) begin
        if (i_push.held_en) begin
            r_mem[r_wr] <= i_push.held;
        end
        if (i_push.last_en) begin
            r_mem[last_addr] <= i_push.last;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OQ_AW'(push_cnt);
            r_rd  <= r_rd + OQ_AW'(pop);
            r_cnt <= r_cnt + OQ_CW'(push_cnt) - OQ_CW'(pop);
        end
    end

endmodule

>>> hw/rtl/commit_header_field_tagger.sv
// Path: a byte passes the input register, then waits in the hold stage until the following byte is taken,
// and is then written to the output queue; the last byte of an object goes from the input register
// straight into the queue, behind its held predecessor when there is one.
// Throughput: one byte per cycle while the consumer takes every beat; the four-entry output
// queue absorbs the extra beat of a final byte, so only output back-pressure stalls the input.
// Reset: synchronous, active low; clears the parser, the hold stage and the queue at once.
module commit_header_field_tagger (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_field_tag,
    output logic       o_end_of_object,
    output logic [1:0] o_parse_status
);
    import chftag_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       q_space;
    logic       advance;
    t_push      push;
    t_result    result;

    assign advance    = r_in_valid && q_space;
    assign o_in_ready = !r_in_valid || advance;

    // Input register: takes a beat whenever it is empty or the stored one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_final <= i_final_byte;
        end
    end

    chftag_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .o_push  (push)
    );

    chftag_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (q_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_out_byte      = result.out_byte;
    assign o_field_tag     = result.field_tag;
    assign o_end_of_object = result.end_of_object;
    assign o_parse_status  = result.parse_status;

endmodule

>>> hw/rtl/chftag_chk.sv
`include "commit_header_field_tagger_assert.svh"

module chftag_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_data_byte,
    input logic       i_final_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic [3:0] o_field_tag,
    input logic       o_end_of_object,
    input logic [1:0] o_parse_status
);
    import chftag_pkg::*;

    // A waiting input beat keeps its payload until it is taken.
    `CHFT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_data_byte) && $stable(i_final_byte), "waiting input beat changed")

    // A stalled result beat keeps its byte, tag and end-of-object flag.
    `CHFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_field_tag) && $stable(o_end_of_object), "stalled result beat changed")

    // Status is only carried on the last byte of an object.
    `CHFT_ASSERT_NOW(a_status_eoo, i_clk, i_rst_n, o_out_valid && !o_end_of_object, o_parse_status == ST_OK, "status set on a non-final beat")

    // Tags stay within the defined fields.
    `CHFT_ASSERT_NOW(a_tag_range, i_clk, i_rst_n, o_out_valid, o_field_tag <= TAG_MESSAGE, "field tag out of range")

    // A status beat holds one of the three defined codes.
    `CHFT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid && o_end_of_object, o_parse_status == ST_OK || o_parse_status == ST_MALFORMED || o_parse_status == ST_NO_MESSAGE, "undefined parse status")

endmodule

bind commit_header_field_tagger chftag_chk u_chk (.*);

>>> verif/commit_tag_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the commit header field tagger, predicts the tagged
// beats that every accepted input byte releases and compares them, oldest first,
// with the beats that leave the block.
module commit_tag_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [3:0] i_field_tag,
    input  logic       i_end_of_object,
    input  logic [1:0] i_parse_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_checked
);
    import chftag_pkg::*;

    // Where the parser stands inside the commit text.
    typedef enum logic [3:0] {
        PS_LINE_START,
        PS_KEYWORD,
        PS_TREE_ID,
        PS_PARENT_ID,
        PS_NAME,
        PS_EMAIL,
        PS_EMAIL_GAP,
        PS_DATE,
        PS_ZONE,
        PS_UNKNOWN_GAP,
        PS_MESSAGE
    } t_header_phase;

    t_header_phase phase;
    logic [3:0]    kw_pos;
    logic [2:0]    kw_cand;
    t_result       held;
    logic          held_ok;
    logic          bad_field;
    logic          saw_message;

    t_result tagged_q[$];
    int      errors;
    int      beats;

    function automatic string keyword_text(input logic [2:0] cand);
        string word;
        case (cand)
            KW_TREE:      word = "tree";
            KW_PARENT:    word = "parent";
            KW_AUTHOR:    word = "author";
            KW_COMMITTER: word = "committer";
            default:      word = "";
        endcase
        return word;
    endfunction

    function automatic void clear_parser();
        phase       = PS_LINE_START;
        kw_pos      = 4'd0;
        kw_cand     = KW_NONE;
        held        = '0;
        held_ok     = 1'b0;
        bad_field   = 1'b0;
        saw_message = 1'b0;
    endfunction

    // Moves the parser on by one byte and returns the tag of that byte.
    function automatic logic [3:0] tag_for_byte(input logic [7:0] b);
        logic [3:0] tag;
        logic [3:0] person;
        string      word;
        tag    = TAG_SEP;
        person = (kw_cand == KW_COMMITTER) ? TAG_COMMITTER_NAME : TAG_AUTHOR_NAME;
        word   = keyword_text(kw_cand);
        case (phase)
            PS_LINE_START: begin
                if (b == CH_NL) begin
                    phase = PS_MESSAGE;
                end else if (b == CH_SP) begin
                    phase = PS_UNKNOWN_GAP;
                end else begin
                    kw_cand = (b == "t") ? KW_TREE :
                              (b == "p") ? KW_PARENT :
                              (b == "a") ? KW_AUTHOR :
                              (b == "c") ? KW_COMMITTER : KW_NONE;
                    kw_pos  = 4'd1;
                    phase   = PS_KEYWORD;
                end
            end
            PS_KEYWORD: begin
                if (b == CH_NL) begin
                    // A header line without any space.
                    bad_field = 1'b1;
                    phase     = PS_LINE_START;
                end else if (b == CH_SP) begin
                    if (kw_cand != KW_NONE && kw_pos == word.len()) begin
                        phase = (kw_cand == KW_TREE)   ? PS_TREE_ID :
                                (kw_cand == KW_PARENT) ? PS_PARENT_ID : PS_NAME;
                    end else begin
                        phase = PS_UNKNOWN_GAP;
                    end
                end else if (kw_cand != KW_NONE && kw_pos < word.len() &&
                             b == word[kw_pos]) begin
                    kw_pos = kw_pos + 4'd1;
                end else begin
                    kw_cand = KW_NONE;
                end
            end
            PS_TREE_ID, PS_PARENT_ID: begin
                if (b == CH_NL) begin
                    phase = PS_LINE_START;
                end else begin
                    tag = (phase == PS_TREE_ID) ? TAG_TREE : TAG_PARENT;
                end
            end
            PS_NAME: begin
                if (b == CH_LT) begin
                    // The byte before the opening bracket becomes a separator.
                    if (held_ok) begin
                        held.field_tag = TAG_SEP;
                    end
                    phase = PS_EMAIL;
                end else if (b == CH_NL) begin
                    bad_field = 1'b1;
                    phase     = PS_LINE_START;
                end else begin
                    tag = person;
                end
            end
            PS_EMAIL: begin
                if (b == CH_GT) begin
                    phase = PS_EMAIL_GAP;
                end else if (b == CH_NL) begin
                    bad_field = 1'b1;
                    phase     = PS_LINE_START;
                end else begin
                    tag = person + 4'd1;
                end
            end
            PS_EMAIL_GAP: begin
                phase = PS_DATE;
            end
            PS_DATE: begin
                if (b == CH_SP) begin
                    phase = PS_ZONE;
                end else if (b == CH_NL) begin
                    bad_field = 1'b1;
                    phase     = PS_LINE_START;
                end else begin
                    tag = person + 4'd2;
                end
            end
            PS_ZONE: begin
                if (b == CH_NL) begin
                    phase = PS_LINE_START;
                end else begin
                    tag = person + 4'd3;
                end
            end
            PS_UNKNOWN_GAP: begin
                phase = PS_MESSAGE;
            end
            default: begin
                phase       = PS_MESSAGE;
                saw_message = 1'b1;
                tag         = TAG_MESSAGE;
            end
        endcase
        return tag;
    endfunction

    // Queues the beats released by one accepted input byte.
    function automatic void predict_beats(input logic [7:0] b, input logic fin);
        logic [3:0] tag;
        logic       open_line;
        t_result    closing;
        tag = tag_for_byte(b);
        if (held_ok) begin
            tagged_q.push_back(held);
        end
        if (fin) begin
            open_line = phase != PS_LINE_START && phase != PS_MESSAGE &&
                        phase != PS_UNKNOWN_GAP;
            closing.out_byte      = b;
            closing.field_tag     = tag;
            closing.end_of_object = 1'b1;
            closing.parse_status  = (bad_field || open_line) ? ST_MALFORMED :
                                    saw_message ? ST_OK : ST_NO_MESSAGE;
            tagged_q.push_back(closing);
            clear_parser();
        end else begin
            held.out_byte      = b;
            held.field_tag     = tag;
            held.end_of_object = 1'b0;
            held.parse_status  = ST_OK;
            held_ok            = 1'b1;
        end
    endfunction

    function automatic void flag_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function automatic void check_beat();
        t_result want;
        if (tagged_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got byte %02h tag %0d end %0b status %0d",
                     $time, i_out_byte, i_field_tag, i_end_of_object, i_parse_status);
        end else begin
            want = tagged_q.pop_front();
            beats++;
            flag_field("out_byte", want.out_byte, i_out_byte);
            flag_field("field_tag", want.field_tag, i_field_tag);
            flag_field("end_of_object", want.end_of_object, i_end_of_object);
            flag_field("parse_status", want.parse_status, i_parse_status);
        end
    endfunction

    // Output beats are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            tagged_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_beat();
            end
            if (i_in_valid && i_in_ready) begin
                predict_beats(i_data_byte, i_final_byte);
            end
        end
        o_fail_count    <= errors;
        o_pending       <= tagged_q.size();
        o_beats_checked <= beats;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import chftag_pkg::*;

    localparam int BYTE_TARGET  = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT_BEAT = 200;
    localparam int HOLD_CYCLES  = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic [3:0] o_field_tag;
    logic       o_end_of_object;
    logic [1:0] o_parse_status;

    int fail_count;
    int pending;
    int beats_checked;

    logic [7:0] commit_text[$];
    logic       fast_sender;
    logic       fast_receiver;
    int         bytes_sent;
    int         objects_sent;
    int         clean_objects;
    int         damaged_objects;
    int         noise_objects;
    int         beats_taken;
    int         cycles;

    commit_header_field_tagger dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_field_tag    (o_field_tag),
        .o_end_of_object(o_end_of_object),
        .o_parse_status (o_parse_status)
    );

    commit_tag_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_byte     (o_out_byte),
        .i_field_tag    (o_field_tag),
        .i_end_of_object(o_end_of_object),
        .i_parse_status (o_parse_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_beats_checked(beats_checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Safety net against a hung handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Random bytes, at least half of them printable, never equal to either excluded value.
    function automatic logic [7:0] pick_byte(input logic [7:0] not_a, input logic [7:0] not_b);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 1) ? $urandom_range(32, 126) : $urandom_range(0, 255));
        end while (b == not_a || b == not_b);
        return b;
    endfunction

    function automatic void add_run(input int lo, input int hi,
                                    input logic [7:0] not_a, input logic [7:0] not_b);
        repeat ($urandom_range(lo, hi)) commit_text.push_back(pick_byte(not_a, not_b));
    endfunction

    function automatic void add_free(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) commit_text.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) commit_text.push_back(s[i]);
    endfunction

    // Name, optional space, bracketed email, one byte of any value, date and zone.
    function automatic void add_person(input string keyword);
        add_text(keyword);
        commit_text.push_back(CH_SP);
        add_run(0, 4, CH_LT, CH_NL);
        if ($urandom_range(0, 3) != 0) commit_text.push_back(CH_SP);
        commit_text.push_back(CH_LT);
        add_run(0, 4, CH_GT, CH_NL);
        commit_text.push_back(CH_GT);
        commit_text.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : CH_SP);
        add_run(1, 4, CH_SP, CH_NL);
        commit_text.push_back(CH_SP);
        add_run(1, 3, CH_NL, CH_NL);
        commit_text.push_back(CH_NL);
    endfunction

    function automatic void build_commit();
        commit_text.delete();
        if ($urandom_range(0, 4) != 0) begin
            add_text("tree ");
            add_run(1, 4, CH_NL, CH_NL);
            commit_text.push_back(CH_NL);
        end
        repeat ($urandom_range(0, 2)) begin
            add_text("parent ");
            add_run(1, 4, CH_NL, CH_NL);
            commit_text.push_back(CH_NL);
        end
        if ($urandom_range(0, 5) != 0) add_person("author");
        if ($urandom_range(0, 5) != 0) add_person("committer");
        case ($urandom_range(0, 7))
            0: begin
                // Headers only, nothing after them.
            end
            1, 2: begin
                // An unknown or near-miss keyword ends the headers.
                case ($urandom_range(0, 4))
                    0:       add_text("gpgsig ");
                    1:       add_text("tre ");
                    2:       add_text("authors ");
                    3:       add_text("committe ");
                    default: commit_text.push_back(CH_SP);
                endcase
                add_free(0, 6);
            end
            default: begin
                commit_text.push_back(CH_NL);
                add_free(0, 8);
            end
        endcase
        if (commit_text.size() == 0) commit_text.push_back(CH_NL);
    endfunction

    function automatic logic [7:0] special_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = CH_NL;
            1:       b = CH_SP;
            2:       b = CH_LT;
            3:       b = CH_GT;
            4:       b = "t";
            5:       b = "a";
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // A well-formed commit cut short or with one byte swapped for a grammar byte or a random value.
    function automatic void build_damaged();
        int cut;
        build_commit();
        if ($urandom_range(0, 1)) begin
            cut = $urandom_range(1, commit_text.size());
            while (commit_text.size() > cut) void'(commit_text.pop_back());
        end else begin
            commit_text[$urandom_range(0, commit_text.size() - 1)] = special_byte();
        end
    endfunction

    function automatic void build_noise();
        commit_text.delete();
        repeat ($urandom_range(1, 10)) commit_text.push_back(special_byte());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = fast_sender ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        bytes_sent++;
    endtask

    task automatic send_commit();
        for (int i = 0; i < commit_text.size(); i++) begin
            send_byte(commit_text[i], i == commit_text.size() - 1);
        end
        objects_sent++;
    endtask

    // Receiver: random stalls per beat, stall-free stretches, and one long hold-off
    // so that the output queue fills and the block refuses input.
    initial begin
        int stall;
        fast_receiver = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        stall = 0;
        forever begin
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            beats_taken++;
            if (beats_taken % 25 == 0) fast_receiver = ($urandom_range(0, 2) == 0);
            if (beats_taken == HOLD_AT_BEAT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = fast_receiver ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // Sender and verdict.
    initial begin
        fast_sender = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A lone empty line: headers end at once and no message follows.
        commit_text = '{CH_NL};
        send_commit();
        // Message made of the extreme byte values.
        commit_text = '{CH_NL, 8'hFF, 8'h00};
        send_commit();
        // Empty keyword: the byte after its space is skipped, then message.
        commit_text = '{CH_SP, 8'h7A, 8'h00};
        send_commit();
        // Header line without a space.
        commit_text.delete();
        add_text("ab");
        commit_text.push_back(CH_NL);
        send_commit();
        // Object that stops inside a tree line.
        commit_text.delete();
        add_text("tree a");
        send_commit();
        // Unknown keyword, skipped byte, then a newline as message.
        commit_text.delete();
        add_text("a x");
        commit_text.push_back(CH_NL);
        send_commit();
        // Person line with its bracket missing.
        commit_text.delete();
        add_text("author ");
        commit_text.push_back(CH_NL);
        send_commit();

        while (bytes_sent < BYTE_TARGET) begin
            fast_sender = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    build_damaged();
                    damaged_objects++;
                end
                3, 4, 5: begin
                    build_noise();
                    noise_objects++;
                end
                default: begin
                    build_commit();
                    clean_objects++;
                end
            endcase
            send_commit();
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes in %0d objects: %0d well-formed, %0d damaged, %0d noise.",
                 bytes_sent, objects_sent, clean_objects, damaged_objects, noise_objects);
        $display("Checked %0d tagged beats, with one long output hold-off of %0d cycles.",
                 beats_checked, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
